// File: hdl/dq_pkg.sv
`default_nettype none

package dq_pkg;

    localparam int DEPTH_DEF  = 256;
    localparam int DATA_W_DEF = 32;

    localparam int ACTION_W = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;

    localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_READ       = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_PEEK_FRONT = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_PEEK_BACK  = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_CLEAR      = 3'd7;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic load;
        logic exec;
    } dq_cmd_t;

endpackage

`default_nettype wire

// File: hdl/dq_ctrl.sv
`default_nettype none

module dq_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           item_valid,
    output logic                item_stall,
    output logic                result_valid,
    input  wire logic           result_stall,
    output dq_pkg::dq_cmd_t     cmd
);
    import dq_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_RESP = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!result_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = (state_reg == S_RESP);
    assign cmd.load     = (state_reg == S_IDLE) && item_valid;
    assign cmd.exec     = (state_reg == S_EXEC);

endmodule

`default_nettype wire

// File: hdl/dq_datapath.sv
`default_nettype none

module dq_datapath #(
    parameter int DEPTH  = dq_pkg::DEPTH_DEF,
    parameter int DATA_W = dq_pkg::DATA_W_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire dq_pkg::dq_cmd_t               cmd,
    input  wire logic [dq_pkg::ACTION_W-1:0]   action,
    input  wire logic [dq_pkg::VALUE_W-1:0]    value,
    input  wire logic [dq_pkg::POS_W-1:0]      position,
    output logic [dq_pkg::VALUE_W-1:0]         data,
    output logic [dq_pkg::STATUS_W-1:0]        status,
    output logic [dq_pkg::COUNT_W-1:0]         count
);
    import dq_pkg::*;

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int SUM_W  = PTR_W + 1;
    localparam int CMP_W  = (FILL_W > POS_W) ? FILL_W : POS_W;

    logic [PTR_W-1:0]    front_reg;
    logic [PTR_W-1:0]    front_next;
    logic [FILL_W-1:0]   fill_reg;
    logic [FILL_W-1:0]   fill_next;

    logic [DATA_W-1:0]   mem [DEPTH];
    logic [DATA_W-1:0]   rd_data_reg;
    logic [DATA_W-1:0]   wr_data_reg;
    logic [PTR_W-1:0]    addr_reg;
    logic [PTR_W-1:0]    addr_next;
    logic                rd_en_reg;
    logic                rd_en_next;
    logic                wr_en_reg;
    logic                wr_en_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;

    logic                full;
    logic                empty;
    logic [PTR_W-1:0]    front_dec;
    logic [PTR_W-1:0]    front_inc;
    logic [PTR_W-1:0]    offset;
    logic [SUM_W-1:0]    sum;
    logic [PTR_W-1:0]    slot;
    logic                pos_past_fill;

    assign full          = (fill_reg == FILL_W'(DEPTH));
    assign empty         = (fill_reg == '0);
    assign front_dec     = (front_reg == '0) ? PTR_W'(DEPTH - 1) : front_reg - PTR_W'(1);
    assign front_inc     = (front_reg == PTR_W'(DEPTH - 1)) ? '0 : front_reg + PTR_W'(1);
    assign pos_past_fill = (CMP_W'(position) >= CMP_W'(fill_reg));

    always_comb
    begin
        case (action)
            ACT_PUSH_BACK:
            begin
                offset = PTR_W'(fill_reg);
            end
            ACT_POP_BACK, ACT_PEEK_BACK:
            begin
                offset = PTR_W'(fill_reg - FILL_W'(1));
            end
            default:
            begin
                offset = PTR_W'(position);
            end
        endcase
    end

    assign sum  = SUM_W'(front_reg) + SUM_W'(offset);
    assign slot = (sum >= SUM_W'(DEPTH)) ? PTR_W'(sum - SUM_W'(DEPTH)) : PTR_W'(sum);

    always_comb
    begin
        front_next  = front_reg;
        fill_next   = fill_reg;
        addr_next   = slot;
        rd_en_next  = 1'b0;
        wr_en_next  = 1'b0;
        status_next = ST_OK;
        case (action)
            ACT_PUSH_FRONT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    addr_next  = front_dec;
                    wr_en_next = 1'b1;
                    front_next = front_dec;
                    fill_next  = fill_reg + FILL_W'(1);
                end
            end
            ACT_PUSH_BACK:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    wr_en_next = 1'b1;
                    fill_next  = fill_reg + FILL_W'(1);
                end
            end
            ACT_POP_FRONT:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    addr_next  = front_reg;
                    rd_en_next = 1'b1;
                    front_next = front_inc;
                    fill_next  = fill_reg - FILL_W'(1);
                end
            end
            ACT_POP_BACK:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    rd_en_next = 1'b1;
                    fill_next  = fill_reg - FILL_W'(1);
                end
            end
            ACT_READ:
            begin
                if (pos_past_fill)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    rd_en_next = 1'b1;
                end
            end
            ACT_PEEK_FRONT:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    addr_next  = front_reg;
                    rd_en_next = 1'b1;
                end
            end
            ACT_PEEK_BACK:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    rd_en_next = 1'b1;
                end
            end
            default:
            begin
                front_next = '0;
                fill_next  = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            fill_reg  <= '0;
            rd_en_reg <= 1'b0;
            wr_en_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            front_reg <= front_next;
            fill_reg  <= fill_next;
            rd_en_reg <= rd_en_next;
            wr_en_reg <= wr_en_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            addr_reg    <= addr_next;
            status_reg  <= status_next;
            wr_data_reg <= DATA_W'(value);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && wr_en_reg)
        begin
            mem[addr_reg] <= wr_data_reg;
        end
        if (cmd.exec && rd_en_reg)
        begin
            rd_data_reg <= mem[addr_reg];
        end
    end

    assign data   = rd_en_reg ? VALUE_W'(rd_data_reg) : '0;
    assign status = status_reg;
    assign count  = COUNT_W'(fill_reg);

endmodule

`default_nettype wire

// File: hdl/double_ended_queue_top.sv
// An item is registered when taken in the idle state, reaches the store in the
// execute state and its result is offered in the response state. A new item is
// taken only after the previous result transfers; load, store access and response
// run in turn. Reset: rst_n clears the queue to empty and the front pointer to
// zero; store contents are not cleared.
`default_nettype none

module double_ended_queue_top #(
    parameter int DEPTH  = dq_pkg::DEPTH_DEF,
    parameter int DATA_W = dq_pkg::DATA_W_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          item_valid,
    output logic                               item_stall,
    input  wire logic [dq_pkg::ACTION_W-1:0]   action,
    input  wire logic [dq_pkg::VALUE_W-1:0]    value,
    input  wire logic [dq_pkg::POS_W-1:0]      position,
    output logic                               result_valid,
    input  wire logic                          result_stall,
    output logic [dq_pkg::VALUE_W-1:0]         data,
    output logic [dq_pkg::STATUS_W-1:0]        status,
    output logic [dq_pkg::COUNT_W-1:0]         count
);
    import dq_pkg::*;

    dq_cmd_t cmd;

    dq_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd)
    );

    dq_datapath #(
        .DEPTH  (DEPTH),
        .DATA_W (DATA_W)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .action   (action),
        .value    (value),
        .position (position),
        .data     (data),
        .status   (status),
        .count    (count)
    );

endmodule

`default_nettype wire

// File: hdl/dq_checker.sv
`default_nettype none

module dq_checker #(
    parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          item_valid,
    input wire logic                          item_stall,
    input wire logic                          result_valid,
    input wire logic                          result_stall,
    input wire logic [dq_pkg::VALUE_W-1:0]    data,
    input wire logic [dq_pkg::STATUS_W-1:0]   status,
    input wire logic [dq_pkg::COUNT_W-1:0]    count
);
    import dq_pkg::*;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |-> ##2 result_valid)
        else $error("result not valid two cycles after item transfer");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> item_stall)
        else $error("item taken while a result is pending");

    a_refused_data: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status != ST_OK |-> data == '0)
        else $error("refused action returned nonzero data");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status == ST_FULL |-> count == COUNT_W'(DEPTH))
        else $error("full status with queue not full");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(data) && $stable(status)
            && $stable(count))
        else $error("stalled result changed");

endmodule

bind double_ended_queue_top dq_checker #(
    .DEPTH (DEPTH)
) u_dq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .data         (data),
    .status       (status),
    .count        (count)
);

`default_nettype wire
